>>> rtl/core/bba_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_pkg
// Shared types, codes and helpers of the bitmap block allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

  localparam int unsigned WORD_BITS  = 64;
  localparam int unsigned BLKNUM_W   = 32;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned BBU_W      = 4;
  localparam int unsigned OUT_DATA_W = 40;  // status + block, padded to bytes

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  localparam logic CFG_DATA_OFFSET = 1'b0;
  localparam logic CFG_BLOCKS_USED = 1'b1;

  localparam logic [STATUS_W-1:0] STAT_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_NO_FREE = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_RANGE   = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ALLOC,
    ST_ARD,
    ST_AENC,
    ST_FREE,
    ST_FRD,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic ld_in;
    logic alloc_rd;
    logic load_word;
    logic hint_inc;
    logic alloc_set;
    logic free_rd;
    logic free_wr;
    logic res_full;
    logic res_range;
    logic res_ok;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic hint_ge_nwords;
    logic word_full;
    logic out_of_range;
    logic beyond_fill;
    logic out_stall;
  } stat_t;

  // Lowest clear bit of a byte; 7 when only bit 7 is clear (caller checks full).
  function automatic logic [2:0] lowest_clear8(input logic [7:0] b);
    logic [2:0] r;
    r = 3'd7;
    for (int i = 7; i >= 0; i--) begin
      if (!b[i]) begin
        r = 3'(i);
      end
    end
    return r;
  endfunction

endpackage

>>> rtl/core/bba_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_ctrl
// Sequencer for allocate and free requests; drives the datapath commands.
// ----------------------------------------------------------------------------
module bba_ctrl
  import bba_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   in_valid_i,
  input  logic   in_mode_i,
  output logic   in_ready_o,
  input  stat_t  st_i,
  output cmd_t   cmd_o,
  output state_e state_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.ld_in = 1'b1;
          state_d     = (in_mode_i == MODE_FREE) ? ST_FREE : ST_ALLOC;
        end
      end
      ST_ALLOC: begin
        if (st_i.hint_ge_nwords) begin
          cmd_o.res_full = 1'b1;
          state_d        = ST_DONE;
        end else begin
          cmd_o.alloc_rd = 1'b1;
          state_d        = ST_ARD;
        end
      end
      ST_ARD: begin
        cmd_o.load_word = 1'b1;
        if (st_i.word_full) begin
          // skip a full word and look at the next one
          cmd_o.hint_inc = 1'b1;
          state_d        = ST_ALLOC;
        end else begin
          state_d = ST_AENC;
        end
      end
      ST_AENC: begin
        cmd_o.alloc_set = 1'b1;
        state_d         = ST_DONE;
      end
      ST_FREE: begin
        if (st_i.out_of_range) begin
          cmd_o.res_range = 1'b1;
          state_d         = ST_DONE;
        end else if (st_i.beyond_fill) begin
          // word never written, so it is already zero
          cmd_o.res_ok = 1'b1;
          state_d      = ST_DONE;
        end else begin
          cmd_o.res_ok  = 1'b1;
          cmd_o.free_rd = 1'b1;
          state_d       = ST_FRD;
        end
      end
      ST_FRD: begin
        cmd_o.free_wr = 1'b1;
        state_d       = ST_DONE;
      end
      ST_DONE: begin
        if (!st_i.out_stall) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign state_o = state_q;

endmodule

>>> rtl/core/bba_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_dpath
// Bitmap memory, search hint, fill count, bit encoder and result registers.
// ----------------------------------------------------------------------------
module bba_dpath
  import bba_pkg::*;
#(
  parameter int unsigned BLOCK_BYTES       = 512,
  parameter int unsigned MAX_BITMAP_BLOCKS = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic                  cfg_idx_i,
  input  logic [BLKNUM_W-1:0]   cfg_data_i,
  input  logic [BLKNUM_W-1:0]   in_block_i,
  input  cmd_t                  cmd_i,
  output stat_t                 st_o,
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  output logic [STATUS_W-1:0]   out_status_o,
  output logic [BLKNUM_W-1:0]   out_block_o
);

  localparam int unsigned WORDS_PER_BLK = BLOCK_BYTES / 8;
  localparam int unsigned STORE_WORDS   = MAX_BITMAP_BLOCKS * WORDS_PER_BLK;
  localparam int unsigned WIDX_W = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
  localparam int unsigned CNT_W  = $clog2(STORE_WORDS + 1);
  localparam int unsigned RELW_W = BLKNUM_W - 6;

  // bitmap words; entries at or above fill_q were never written and read as zero
  logic [WORD_BITS-1:0] mem_q [STORE_WORDS];
  logic [WORD_BITS-1:0] rdata_q;

  logic [BLKNUM_W-1:0]  off_q;
  logic [BBU_W-1:0]     bbu_q;
  logic [BLKNUM_W-1:0]  bn_q;
  logic [CNT_W-1:0]     hint_q;   // every word below it is full
  logic [CNT_W-1:0]     fill_q;
  logic [WORD_BITS-1:0] word_q;
  logic [7:0]           nf_q;
  logic [2:0]           lc_q [8];
  logic [WIDX_W-1:0]    widx_q;
  logic [5:0]           bit_q;
  logic [STATUS_W-1:0]  res_status_q;
  logic [BLKNUM_W-1:0]  res_block_q;
  logic                 out_valid_q;
  logic [STATUS_W-1:0]  out_status_q;
  logic [BLKNUM_W-1:0]  out_block_q;

  logic [31:0]          biu_eff;
  logic [CNT_W-1:0]     nwords;
  logic [BLKNUM_W-1:0]  rel;
  logic [RELW_W-1:0]    rel_word;
  logic [WORD_BITS-1:0] rd_word;
  logic [2:0]           sel;
  logic [5:0]           bit_sel;
  logic [WORD_BITS-1:0] new_word;
  logic                 mem_we;
  logic [WIDX_W-1:0]    mem_wa;
  logic [WORD_BITS-1:0] mem_wd;
  logic [WIDX_W-1:0]    mem_ra;

  // words in use, bitmap block count clamped to the store size
  assign biu_eff = (32'(bbu_q) > MAX_BITMAP_BLOCKS) ? 32'(MAX_BITMAP_BLOCKS)
                                                     : 32'(bbu_q);
  assign nwords  = CNT_W'(biu_eff * 32'(WORDS_PER_BLK));

  assign rel      = bn_q - off_q;
  assign rel_word = rel[BLKNUM_W-1:6];
  assign rd_word  = (hint_q < fill_q) ? rdata_q : '0;

  always_comb begin
    sel = 3'd0;
    for (int g = 7; g >= 0; g--) begin
      if (nf_q[g]) begin
        sel = 3'(g);
      end
    end
  end

  assign bit_sel  = {sel, lc_q[sel]};
  assign new_word = word_q | (64'd1 << bit_sel);

  assign st_o.hint_ge_nwords = (hint_q >= nwords);
  assign st_o.word_full      = &rd_word;
  assign st_o.out_of_range   = (rel_word >= RELW_W'(nwords));
  assign st_o.beyond_fill    = (rel_word >= RELW_W'(fill_q));
  assign st_o.out_stall      = out_valid_q && !out_ready_i;

  assign mem_we = cmd_i.alloc_set || cmd_i.free_wr;
  assign mem_wa = cmd_i.alloc_set ? hint_q[WIDX_W-1:0] : widx_q;
  assign mem_wd = cmd_i.alloc_set ? new_word : (rdata_q & ~(64'd1 << bit_q));
  assign mem_ra = cmd_i.alloc_rd ? hint_q[WIDX_W-1:0] : rel_word[WIDX_W-1:0];

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.alloc_rd || cmd_i.free_rd) begin
      rdata_q <= mem_q[mem_ra];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q <= '0;
      bbu_q <= BBU_W'(8);
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_DATA_OFFSET) begin
        off_q <= cfg_data_i;
      end else begin
        bbu_q <= cfg_data_i[BBU_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hint_q <= '0;
      fill_q <= '0;
    end else begin
      if (cmd_i.hint_inc) begin
        hint_q <= hint_q + CNT_W'(1);
      end else if (cmd_i.alloc_set) begin
        if (&new_word) begin
          hint_q <= hint_q + CNT_W'(1);
        end
        if (hint_q == fill_q) begin
          fill_q <= fill_q + CNT_W'(1);
        end
      end else if (cmd_i.free_wr) begin
        if (CNT_W'(widx_q) < hint_q) begin
          hint_q <= CNT_W'(widx_q);
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_in) begin
      bn_q <= in_block_i;
    end
    if (cmd_i.load_word) begin
      word_q <= rd_word;
      for (int g = 0; g < 8; g++) begin
        nf_q[g] <= ~&rd_word[8*g +: 8];
        lc_q[g] <= lowest_clear8(rd_word[8*g +: 8]);
      end
    end
    if (cmd_i.free_rd) begin
      widx_q <= rel_word[WIDX_W-1:0];
      bit_q  <= rel[5:0];
    end
    if (cmd_i.res_full) begin
      res_status_q <= STAT_NO_FREE;
      res_block_q  <= '0;
    end else if (cmd_i.res_range) begin
      res_status_q <= STAT_RANGE;
      res_block_q  <= '0;
    end else if (cmd_i.res_ok) begin
      res_status_q <= STAT_OK;
      res_block_q  <= '0;
    end else if (cmd_i.alloc_set) begin
      res_status_q <= STAT_OK;
      res_block_q  <= BLKNUM_W'({hint_q[WIDX_W-1:0], bit_sel}) + off_q;
    end
    if (cmd_i.out_load) begin
      out_status_q <= res_status_q;
      out_block_q  <= res_block_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_block_o  = out_block_q;

endmodule

>>> rtl/core/bitmap_block_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_block_allocator
// First-fit block allocator over a bitmap of used blocks in 64-bit words.
// An allocate reads words from the search hint on, passing over each full word;
// a free reads and writes one word, or neither when out of range or never written.
// The next request is taken the cycle after the result loads, even while that
// result waits for m_axis_tready; no request is taken before then.
// Reset: async active low; bitmap reads as all free via a fill count, no sweep.
// ----------------------------------------------------------------------------
module bitmap_block_allocator
  import bba_pkg::*;
#(
  parameter int unsigned BLOCK_BYTES       = 512,
  parameter int unsigned MAX_BITMAP_BLOCKS = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration
  input  logic                  cfg_we_i,
  input  logic                  cfg_idx_i,
  input  logic [BLKNUM_W-1:0]   cfg_data_i,
  // request stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [BLKNUM_W-1:0]   s_axis_tdata,   // [31:0] block_number
  input  logic                  s_axis_tuser,   // [0] mode
  // result stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata    // [1:0] status, [33:2] allocated_block
);

  cmd_t                cmd;
  stat_t               st;
  state_e              state;
  logic [STATUS_W-1:0] out_status;
  logic [BLKNUM_W-1:0] out_block;

  bba_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_mode_i  (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .st_i       (st),
    .cmd_o      (cmd),
    .state_o    (state)
  );

  bba_dpath #(
    .BLOCK_BYTES       (BLOCK_BYTES),
    .MAX_BITMAP_BLOCKS (MAX_BITMAP_BLOCKS)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_block_i   (s_axis_tdata),
    .cmd_i        (cmd),
    .st_o         (st),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .out_status_o (out_status),
    .out_block_o  (out_block)
  );

  assign m_axis_tdata = {{(OUT_DATA_W - STATUS_W - BLKNUM_W){1'b0}}, out_block, out_status};

  // an allocate never writes a word past the words in use
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.alloc_set |-> !st.hint_ge_nwords)
    else $error("allocate wrote beyond words in use");

  // a pending result is never overwritten
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> !(m_axis_tvalid && !m_axis_tready))
    else $error("result overwritten while stalled");

  // a free write always follows its read
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.free_wr |-> $past(cmd.free_rd))
    else $error("free write without read");

  // a taken request moves on to the allocate or free state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> (state == ST_ALLOC || state == ST_FREE))
    else $error("accepted item not dispatched");

endmodule
